// File: design/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions of the Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h3D;   // '='
    localparam logic [6:0] BAD_INDEX = 7'd64;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ENC_FULL,
        OP_ENC_ONE,
        OP_ENC_TWO,
        OP_DEC
    } t_op;

    // One group ready for output: raw bytes (encode) or indices (decode)
    typedef struct packed {
        t_op        op;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        c = 8'd47;
        if (idx < 6'd26) begin
            c = 8'd65 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'd71 + {2'b00, idx};
        end else if (idx < 6'd62) begin
            c = {2'b00, idx} - 8'd4;
        end else if (idx == 6'd62) begin
            c = 8'd43;
        end
        return c;
    endfunction

    function automatic logic [6:0] b64_index(input logic [7:0] c);
        logic [6:0] k;
        k = BAD_INDEX;
        if (c >= 8'd65 && c <= 8'd90) begin
            k = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            k = 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            k = 7'(c + 8'd4);
        end else if (c == 8'd43) begin
            k = 7'd62;
        end else if (c == 8'd47) begin
            k = 7'd63;
        end
        return k;
    endfunction

endpackage

// File: design/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input items, gathers groups and queues one job per finished group.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    input  b64c_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    input  b64c_pkg::t_qstat   i_qstat,
    output logic               o_push,
    output b64c_pkg::t_job     o_job
);
    import b64c_pkg::*;

    logic       r_mode;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [7:0] r_hold [3];
    logic [7:0] n_hold [3];
    logic       accept;
    logic [6:0] k;
    logic [7:0] b;

    assign o_in_stall = i_qstat.full;
    assign accept     = i_in_valid && !i_qstat.full;
    assign b          = i_in_item.in_byte;
    assign k          = b64_index(b);

    always_comb begin
        n_count = r_count;
        n_hold  = r_hold;
        o_push  = 1'b0;
        o_job   = '{op: OP_ENC_FULL, d0: r_hold[0], d1: r_hold[1], d2: b, d3: 8'd0};
        if (accept) begin
            if (!r_mode) begin
                if (r_count == 2'd2) begin
                    o_push  = 1'b1;
                    n_count = 2'd0;
                end else begin
                    n_hold[r_count[0]] = b;
                    n_count = r_count + 2'd1;
                    if (i_in_item.in_last) begin
                        o_push = 1'b1;
                        if (r_count == 2'd0) begin
                            o_job.op = OP_ENC_ONE;
                            o_job.d0 = b;
                        end else begin
                            o_job.op = OP_ENC_TWO;
                            o_job.d1 = b;
                        end
                    end
                end
            end else begin
                if (r_count == 2'd3) begin
                    o_push   = 1'b1;
                    o_job.op = OP_DEC;
                    o_job.d2 = r_hold[2];
                    o_job.d3 = {1'b0, k};
                    n_count  = 2'd0;
                end else begin
                    n_hold[r_count] = {1'b0, k};
                    n_count = r_count + 2'd1;
                end
            end
            // a final item always closes the group
            if (i_in_item.in_last) begin
                n_count = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= 2'd0;
        end else if (i_cfg_we) begin
            r_mode  <= i_cfg_data;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("job pushed without an accepted item");
    a_enc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_mode && !$past(i_cfg_we)) |-> (r_count != 2'd3))
        else $error("encode group count out of range");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.in_last && !i_cfg_we) |=> (r_count == 2'd0))
        else $error("group not cleared after final item");

endmodule

// File: design/b64c_queue.sv
// ----------------------------------------------------------------------------
// b64c_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64c_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64c_pkg::t_job   i_job,
    input  logic             i_pop,
    output b64c_pkg::t_job   o_head,
    output b64c_pkg::t_qstat o_qstat
);
    import b64c_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: design/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back
// Expands the job at the queue head into result items, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64c_pkg::t_job      i_job,
    input  b64c_pkg::t_qstat    i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    output b64c_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import b64c_pkg::*;

    logic       r_out_valid;
    t_out_item  r_out;
    logic [1:0] r_step;
    logic [1:0] n_step;
    logic [1:0] last_step;
    logic       slot_last;
    logic       load;
    logic [7:0] slot_byte;
    logic [7:0] dec_b1;
    logic [7:0] dec_b2;
    logic [7:0] dec_b3;
    logic       i2_ok;
    logic       k_ok;

    // decoded bytes wrap to eight bits, bad indices still feed the sums
    assign dec_b1 = {i_job.d0[5:0], 2'b00} + {5'd0, i_job.d1[6:4]};
    assign dec_b2 = {i_job.d1[3:0], 4'd0} + {3'd0, i_job.d2[6:2]};
    assign dec_b3 = {i_job.d2[1:0], 6'd0} + i_job.d3;
    assign i2_ok  = (i_job.d2[6:0] != BAD_INDEX);
    assign k_ok   = (i_job.d3[6:0] != BAD_INDEX);

    always_comb begin
        last_step = 2'd3;
        slot_byte = PAD_CHAR;
        case (i_job.op)
            OP_ENC_FULL: begin
                case (r_step)
                    2'd0:    slot_byte = b64_char(i_job.d0[7:2]);
                    2'd1:    slot_byte = b64_char({i_job.d0[1:0], i_job.d1[7:4]});
                    2'd2:    slot_byte = b64_char({i_job.d1[3:0], i_job.d2[7:6]});
                    default: slot_byte = b64_char(i_job.d2[5:0]);
                endcase
            end
            OP_ENC_ONE: begin
                case (r_step)
                    2'd0:    slot_byte = b64_char(i_job.d0[7:2]);
                    2'd1:    slot_byte = b64_char({i_job.d0[1:0], 4'd0});
                    default: slot_byte = PAD_CHAR;
                endcase
            end
            OP_ENC_TWO: begin
                case (r_step)
                    2'd0:    slot_byte = b64_char(i_job.d0[7:2]);
                    2'd1:    slot_byte = b64_char({i_job.d0[1:0], i_job.d1[7:4]});
                    2'd2:    slot_byte = b64_char({i_job.d1[3:0], 2'd0});
                    default: slot_byte = PAD_CHAR;
                endcase
            end
            OP_DEC: begin
                last_step = {1'b0, i2_ok} + {1'b0, k_ok};
                case (r_step)
                    2'd0:    slot_byte = dec_b1;
                    2'd1:    slot_byte = i2_ok ? dec_b2 : dec_b3;
                    default: slot_byte = dec_b3;
                endcase
            end
            default: begin
                slot_byte = PAD_CHAR;
            end
        endcase
    end

    assign slot_last = (r_step == last_step);
    assign load      = !r_out_valid || !i_out_stall;
    assign o_pop     = load && !i_qstat.empty && slot_last;
    assign n_step    = slot_last ? 2'd0 : r_step + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= 2'd0;
        end else if (load) begin
            r_out_valid <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_qstat.empty) begin
            r_out <= '{out_byte: slot_byte, out_last: slot_last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_step_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 2'd0) |-> !i_qstat.empty)
        else $error("mid-job step with empty queue");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> (r_step <= last_step))
        else $error("step beyond the job's last result");
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out.out_last))
        else $error("job retired without a final result");

endmodule

// File: design/base64_codec_top.sv
// ----------------------------------------------------------------------------
// base64_codec_top
// Base64 encoder and decoder for one message, mode chosen by register.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid, i_in_item (byte and last marker), o_in_stall.
// Output channel: o_out_valid, o_out_item (byte and last marker), i_out_stall.
// A transfer happens at a clock edge with valid high and stall low.
// Mode register: i_cfg_data is written when i_cfg_we is high; 0 encodes,
// 1 decodes. A write drops any partial group; write only while idle.
// Encode: three bytes give four characters; a final item closes a partial
// group with '=' padding. Decode: four characters give one to three bytes;
// an incomplete final group is dropped. out_last flags the final result
// of each group.
// The input transfer that completes a group writes a job into the queue, and
// its first result then passes through the output register. Input is taken
// every cycle while the job queue (four groups) has room; the back part sends
// one result per cycle while the receiver does not stall.
// Reset clears the mode to encode, the group and the queue.
// A stalled receiver holds the output register; the queue absorbs groups
// until full, then o_in_stall rises.
// ----------------------------------------------------------------------------
module base64_codec_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    input  b64c_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output b64c_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import b64c_pkg::*;

    t_qstat qstat;
    t_job   push_job;
    t_job   head_job;
    logic   push;
    logic   pop;

    b64c_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    b64c_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_qstat (qstat)
    );

    b64c_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: bench/base64_codec_checker.sv
// ----------------------------------------------------------------------------
// base64_codec_checker
// Watches the codec's channels, predicts every result and compares them.
// ----------------------------------------------------------------------------
// Tracks mode writes and input transfers, keeps its own copy of the group
// state, and queues the characters or bytes that each transfer must give.
// Output transfers are checked in order against that queue.
// ----------------------------------------------------------------------------
module base64_codec_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    input  b64c_pkg::t_in_item  i_in_item,
    input  logic                i_in_stall,
    input  logic                i_out_valid,
    input  b64c_pkg::t_out_item i_out_item,
    input  logic                i_out_stall,
    output int                  o_err_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import b64c_pkg::*;

    localparam logic [8*64-1:0] GLYPHS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       mode_q;
    logic [1:0] grp_n;
    logic [7:0] grp_buf [3];
    t_out_item  codec_results_q [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_checked   = 0;
        mode_q      = 1'b0;
        grp_n       = 2'd0;
        grp_buf     = '{8'd0, 8'd0, 8'd0};
    end

    function automatic logic [7:0] b64_glyph(input logic [5:0] idx);
        return GLYPHS[8*(63 - idx) +: 8];
    endfunction

    function automatic logic [6:0] glyph_index(input logic [7:0] c);
        for (int k = 0; k < 64; k++) begin
            if (b64_glyph(k[5:0]) == c) begin
                return k[6:0];
            end
        end
        return BAD_INDEX;
    endfunction

    // Advance the group state by one transfer and queue what it gives
    task automatic predict_codec(input logic [7:0] b, input logic last);
        logic [7:0]  res [$];
        logic [6:0]  k;
        logic [7:0]  b0;
        logic [7:0]  b1;
        int unsigned i0;
        int unsigned i1;
        int unsigned i2;
        t_out_item   item;
        if (mode_q == 1'b0) begin
            if (grp_n == 2'd2) begin
                b0 = grp_buf[0];
                b1 = grp_buf[1];
                res.push_back(b64_glyph(b0[7:2]));
                res.push_back(b64_glyph({b0[1:0], b1[7:4]}));
                res.push_back(b64_glyph({b1[3:0], b[7:6]}));
                res.push_back(b64_glyph(b[5:0]));
                grp_n = 2'd0;
            end else begin
                grp_buf[grp_n[0]] = b;
                grp_n = grp_n + 2'd1;
                if (last) begin
                    b0 = grp_buf[0];
                    b1 = grp_buf[1];
                    res.push_back(b64_glyph(b0[7:2]));
                    if (grp_n == 2'd1) begin
                        res.push_back(b64_glyph({b0[1:0], 4'd0}));
                        res.push_back(PAD_CHAR);
                    end else begin
                        res.push_back(b64_glyph({b0[1:0], b1[7:4]}));
                        res.push_back(b64_glyph({b1[3:0], 2'd0}));
                    end
                    res.push_back(PAD_CHAR);
                end
            end
        end else begin
            k = glyph_index(b);
            if (grp_n == 2'd3) begin
                i0 = grp_buf[0];
                i1 = grp_buf[1];
                i2 = grp_buf[2];
                // a pad index of 64 still feeds the sums; only the low byte counts
                res.push_back(8'((i0 << 2) + (i1 >> 4)));
                if (i2 != BAD_INDEX) begin
                    res.push_back(8'((i1 << 4) + (i2 >> 2)));
                end
                if (k != BAD_INDEX) begin
                    res.push_back(8'((i2 << 6) + k));
                end
                grp_n = 2'd0;
            end else begin
                grp_buf[grp_n] = {1'b0, k};
                grp_n = grp_n + 2'd1;
            end
        end
        // a final item always closes the group, complete or not
        if (last) begin
            grp_n = 2'd0;
        end
        foreach (res[j]) begin
            item.out_byte = res[j];
            item.out_last = (j == res.size() - 1);
            codec_results_q.push_back(item);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mode_q = 1'b0;
            grp_n  = 2'd0;
            codec_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (codec_results_q.size() == 0) begin
                    $display("%0t: unexpected result, got byte 8'h%02h last %0b",
                             $time, i_out_item.out_byte, i_out_item.out_last);
                    o_err_count = o_err_count + 1;
                end else begin
                    want = codec_results_q.pop_front();
                    o_checked = o_checked + 1;
                    if (i_out_item.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected 8'h%02h, got 8'h%02h",
                                 $time, want.out_byte, i_out_item.out_byte);
                        o_err_count = o_err_count + 1;
                    end
                    if (i_out_item.out_last !== want.out_last) begin
                        $display("%0t: out_last mismatch, expected %0b, got %0b",
                                 $time, want.out_last, i_out_item.out_last);
                        o_err_count = o_err_count + 1;
                    end
                end
            end
            // a mode write drops any partial group
            if (i_cfg_we) begin
                mode_q = i_cfg_data;
                grp_n  = 2'd0;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_codec(i_in_item.in_byte, i_in_item.in_last);
            end
        end
        o_pending = codec_results_q.size();
    end

endmodule

// File: bench/base64_codec_top_tb.sv
// ----------------------------------------------------------------------------
// base64_codec_top_tb
// Stimulus and verdict for the Base64 codec.
// ----------------------------------------------------------------------------
// Runs directed encode and decode messages, then random messages in both
// modes under four handshake pressure phases. The checker module predicts
// and compares; this module drives the block and reports the outcome.
// ----------------------------------------------------------------------------
module base64_codec_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64c_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int BLOCK_ITEMS    = 40;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic MODE_ENCODE  = 1'b0;
    localparam logic MODE_DECODE  = 1'b1;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_data;
    logic      i_in_valid;
    t_in_item  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall;

    int err_count;
    int pending;
    int checked;
    int sent_items  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    base64_codec_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    base64_codec_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .i_in_stall  (o_in_stall),
        .i_out_valid (o_out_valid),
        .i_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // end the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still awaited", $time, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Hold the item until a transfer happens; valid stays up into the next item
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= {b, last};
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int j = 0; j < s.len(); j++) begin
            send_item(s[j], last_at_end && (j == s.len() - 1));
        end
    endtask

    // Drain all expected results, then give the block time to finish up
    task automatic settle(input int extra);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        settle(SETTLE_CYCLES);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_encode_block();
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
    endtask

    // Mostly well-formed messages with random characters, some raw noise
    task automatic random_decode_block();
        int n;
        int quads;
        int pads;
        logic [7:0] c;
        n = 0;
        while (n < BLOCK_ITEMS) begin
            if ($urandom_range(4) == 0) begin
                send_item(8'($urandom_range(255)), $urandom_range(5) == 0);
                n++;
            end else begin
                quads = $urandom_range(1, 4);
                pads  = $urandom_range(0, 2);
                for (int q = 0; q < quads; q++) begin
                    for (int p = 0; p < 4; p++) begin
                        if (q == quads - 1 && p >= 4 - pads) begin
                            c = PAD_CHAR;
                        end else begin
                            c = b64_char(6'($urandom_range(63)));
                        end
                        send_item(c, q == quads - 1 && p == 3);
                        n++;
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: full group, one-byte tail, two-byte tail, full group closed by last
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b1);
        send_item(8'h3F, 1'b0);
        send_item(8'hC0, 1'b0);
        send_item(8'hAA, 1'b1);

        // decode: double pad, single pad, bad characters, pad before a glyph,
        // incomplete final group
        write_mode(MODE_DECODE);
        send_text("TQ==", 1'b1);
        send_text("+/9=", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("=A", 1'b0);
        send_text("TW=", 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 75;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 75;
                end
                default: begin
                    idle_pct  = 36;
                    stall_pct = 36;
                end
            endcase
            write_mode(MODE_ENCODE);
            random_encode_block();
            write_mode(MODE_DECODE);
            random_decode_block();
        end

        settle(20);
        $display("Sent %0d input transfers in encode and decode mode over four pressure phases,",
                 sent_items);
        $display("and compared %0d results.", checked);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
design/b64c_pkg.sv
design/b64c_front.sv
design/b64c_queue.sv
design/b64c_back.sv
design/base64_codec_top.sv
bench/base64_codec_checker.sv
bench/base64_codec_top_tb.sv
